// ----- design/tgpr_pkg.sv -----
// tgpr_pkg: shared types, codes and constants of the text glyph pixel renderer.
// No dependencies; the other design files but tgpr_fifo refer to it by scoped names.
package tgpr_pkg;

  // defaults for the top-level parameters
  localparam int FONT_CHARS_DEF = 256;
  localparam int ADDR_BITS_DEF  = 24;

  // fixed field widths
  localparam int CODE_W     = 8;
  localparam int ROW_W      = 3;
  localparam int BITS_W     = 8;
  localparam int REQ_W      = 2;
  localparam int PIX_ADDR_W = 24;
  localparam int COLOR_W    = 16;
  localparam int PITCH_W    = 12;
  localparam int CUR_X_W    = 10;
  localparam int CUR_Y_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // queue depths
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  // request codes on req_type
  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DRAW = 2'd1;
  localparam logic [REQ_W-1:0] REQ_HOME = 2'd2;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_INK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 1'b1;

  // reset values: green 0x10<<6 | 0xf<<5, and a 640-pixel line
  localparam logic [COLOR_W-1:0] INK_RESET   = 16'd1504;
  localparam logic [PITCH_W-1:0] PITCH_RESET = 12'd640;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DRAW,
    CMD_NEWLINE,
    CMD_HOME
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CODE_W-1:0]    code;
    logic [ROW_W-1:0]     row;
    logic [BITS_W-1:0]    bits;
  } cmd_t;

  typedef struct packed {
    logic [PIX_ADDR_W-1:0] addr;
    logic [COLOR_W-1:0]    color;
    logic                  last;
  } pix_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN
  } back_state_t;

endpackage

// ----- design/tgpr_front.sv -----
// tgpr_front: classifies an incoming request beat into a command for the queue.
// Depends on tgpr_pkg.
module tgpr_front (
  input  logic [tgpr_pkg::REQ_W-1:0]  req_type,
  input  logic [tgpr_pkg::CODE_W-1:0] char_code,
  input  logic [tgpr_pkg::ROW_W-1:0]  glyph_row,
  input  logic [tgpr_pkg::BITS_W-1:0] row_bits,
  input  logic                        push,
  input  logic                        q_full,
  output logic                        q_push,
  output tgpr_pkg::cmd_t              q_item
);

  logic known;

  always_comb begin
    known       = 1'b1;
    q_item.kind = tgpr_pkg::CMD_LOAD;
    q_item.code = char_code;
    q_item.row  = glyph_row;
    q_item.bits = row_bits;
    case (req_type)
      tgpr_pkg::REQ_LOAD: q_item.kind = tgpr_pkg::CMD_LOAD;
      tgpr_pkg::REQ_DRAW: begin
        if (char_code == tgpr_pkg::NEWLINE_CODE) begin
          q_item.kind = tgpr_pkg::CMD_NEWLINE;
        end else begin
          q_item.kind = tgpr_pkg::CMD_DRAW;
        end
      end
      tgpr_pkg::REQ_HOME: q_item.kind = tgpr_pkg::CMD_HOME;
      default: known = 1'b0;  // unknown type: beat taken, then dropped
    endcase
  end

  assign q_push = push && !q_full && known;

endmodule

// ----- design/tgpr_fifo.sv -----
// tgpr_fifo: small first-word-fall-through queue of any packed item type.
// Depends on tgpr_pkg for nothing but house conventions; self-contained.
module tgpr_fifo #(
  parameter type ITEM_T = logic,
  parameter int  DEPTH  = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  ITEM_T wr_item,
  input  logic  rd_en,
  output ITEM_T rd_item,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ITEM_T             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/tgpr_back.sv -----
// tgpr_back: executes queued commands; holds the font store and the cursor,
// fetches a glyph into a shift register and scans it one pixel a cycle
// except where a set pixel meets a full result queue. Depends on tgpr_pkg.
module tgpr_back #(
  parameter int FONT_CHARS = tgpr_pkg::FONT_CHARS_DEF,
  parameter int ADDR_BITS  = tgpr_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_empty,
  input  tgpr_pkg::cmd_t                cmd_item,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output tgpr_pkg::pix_t                res_item,
  input  logic [tgpr_pkg::COLOR_W-1:0]  ink_color,
  input  logic [tgpr_pkg::PITCH_W-1:0]  row_pitch
);

  localparam int GLYPH_W    = $clog2(FONT_CHARS);
  localparam int FONT_AW    = GLYPH_W + tgpr_pkg::ROW_W;
  localparam int FONT_DEPTH = FONT_CHARS * 8;
  localparam int PROD_W     = tgpr_pkg::CUR_Y_W + tgpr_pkg::PITCH_W;

  logic [tgpr_pkg::BITS_W-1:0]  font_mem [FONT_DEPTH];
  logic [tgpr_pkg::BITS_W-1:0]  mem_q;
  logic [FONT_AW-1:0]           rd_addr;
  logic [FONT_AW-1:0]           wr_addr;
  logic                         mem_we;

  tgpr_pkg::back_state_t        state;
  tgpr_pkg::back_state_t        state_next;
  logic [GLYPH_W-1:0]           glyph;
  logic [GLYPH_W-1:0]           cmd_glyph;
  logic [tgpr_pkg::CODE_W:0]    code_ext;
  logic [3:0]                   fetch_cnt;
  logic [5:0]                   scan_cnt;
  logic [63:0]                  bits_sr;
  logic [ADDR_BITS-1:0]         row_addr;
  logic [PROD_W-1:0]            line_prod;
  logic [tgpr_pkg::CUR_X_W-1:0] cur_x;
  logic [tgpr_pkg::CUR_Y_W-1:0] cur_y;
  logic [tgpr_pkg::CUR_X_W:0]   col;
  logic [tgpr_pkg::CUR_X_W:0]   nx;
  logic [ADDR_BITS-1:0]         pix_addr;
  logic                         scan_step;

  // glyph index = code mod FONT_CHARS by one subtract, valid while code < 2*FONT_CHARS
  assign code_ext  = {1'b0, cmd_item.code};
  assign cmd_glyph = (code_ext >= (tgpr_pkg::CODE_W + 1)'(FONT_CHARS))
                   ? GLYPH_W'(code_ext - (tgpr_pkg::CODE_W + 1)'(FONT_CHARS))
                   : GLYPH_W'(code_ext);

  assign rd_addr   = {glyph, fetch_cnt[2:0]};
  assign wr_addr   = {cmd_glyph, cmd_item.row};
  assign line_prod = cur_y * row_pitch;
  assign col       = {1'b0, cur_x} + 11'd8 - {8'd0, scan_cnt[2:0]};
  assign pix_addr  = row_addr + ADDR_BITS'(col);
  assign nx        = {1'b0, cur_x} + 11'd8;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[wr_addr] <= cmd_item.bits;
    end
    mem_q <= font_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tgpr_pkg::ST_IDLE: begin
        if (!cmd_empty && cmd_item.kind == tgpr_pkg::CMD_DRAW) begin
          state_next = tgpr_pkg::ST_FETCH;
        end
      end
      tgpr_pkg::ST_FETCH: begin
        if (fetch_cnt == 4'd8) begin
          state_next = tgpr_pkg::ST_SCAN;
        end
      end
      tgpr_pkg::ST_SCAN: begin
        if (scan_step && scan_cnt == 6'd63) begin
          state_next = tgpr_pkg::ST_IDLE;
        end
      end
      default: state_next = tgpr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop        = 1'b0;
    mem_we         = 1'b0;
    scan_step      = 1'b0;
    res_push       = 1'b0;
    res_item.addr  = tgpr_pkg::PIX_ADDR_W'(pix_addr);
    res_item.color = ink_color;
    res_item.last  = (bits_sr[63:1] == '0);
    case (state)
      tgpr_pkg::ST_IDLE: begin
        cmd_pop = !cmd_empty;
        mem_we  = !cmd_empty && cmd_item.kind == tgpr_pkg::CMD_LOAD;
      end
      tgpr_pkg::ST_SCAN: begin
        scan_step = !bits_sr[0] || !res_full;
        res_push  = bits_sr[0] && !res_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgpr_pkg::ST_IDLE;
      cur_x <= '0;
      cur_y <= '0;
    end else begin
      state <= state_next;
      if (cmd_pop) begin
        case (cmd_item.kind)
          tgpr_pkg::CMD_HOME: begin
            cur_x <= '0;
            cur_y <= '0;
          end
          tgpr_pkg::CMD_NEWLINE: begin
            cur_x <= '0;
            cur_y <= cur_y + 16'd8;
          end
          default: ;
        endcase
      end
      if (scan_step && scan_cnt == 6'd63) begin
        if ({1'b0, nx} > row_pitch) begin
          cur_x <= '0;
          cur_y <= cur_y + 16'd8;
        end else begin
          cur_x <= nx[tgpr_pkg::CUR_X_W-1:0];
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd_item.kind == tgpr_pkg::CMD_DRAW) begin
      glyph     <= cmd_glyph;
      fetch_cnt <= '0;
      row_addr  <= ADDR_BITS'(line_prod);
    end
    if (state == tgpr_pkg::ST_FETCH) begin
      fetch_cnt <= fetch_cnt + 1'b1;
      if (fetch_cnt != 4'd0) begin
        bits_sr <= {mem_q, bits_sr[63:8]};
      end
      scan_cnt <= '0;
    end
    if (scan_step) begin
      bits_sr  <= {1'b0, bits_sr[63:1]};
      scan_cnt <= scan_cnt + 1'b1;
      if (scan_cnt[2:0] == 3'd7) begin
        row_addr <= row_addr + ADDR_BITS'(row_pitch);
      end
    end
  end

endmodule

// ----- design/text_glyph_pixel_renderer.sv -----
// Text glyph pixel renderer, 8x8 font. Requests enter as queue beats (push/full)
// and pass through a 4-deep command queue to the drawing engine, so loads, home
// and newline requests are taken at one a cycle while the queue has room.
// Each command is dequeued by the engine in its idle state; a drawn character
// then reads its eight font rows from the font memory (one registered read a
// cycle) and scans the glyph's 64 pixels, one pixel per cycle whether set or
// clear, though a set pixel waits while the 2-deep result queue is full.
// Each set pixel gives one result beat (empty/pop) with address, ink colour
// and a flag on the glyph's final write. The font store has no reset; draw
// only glyph rows already loaded. Write ink_color / row_pitch only while the
// block is idle. No clearing pass.
// Depends on tgpr_pkg, tgpr_front, tgpr_fifo and tgpr_back.
module text_glyph_pixel_renderer #(
  parameter int FONT_CHARS = tgpr_pkg::FONT_CHARS_DEF,
  parameter int ADDR_BITS  = tgpr_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // request side
  input  logic                             push,
  output logic                             full,
  input  logic [tgpr_pkg::REQ_W-1:0]       req_type,
  input  logic [tgpr_pkg::CODE_W-1:0]      char_code,
  input  logic [tgpr_pkg::ROW_W-1:0]       glyph_row,
  input  logic [tgpr_pkg::BITS_W-1:0]      row_bits,
  // result side
  output logic                             empty,
  input  logic                             pop,
  output logic [tgpr_pkg::PIX_ADDR_W-1:0]  pixel_address,
  output logic [tgpr_pkg::COLOR_W-1:0]     pixel_color,
  output logic                             last_pixel,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tgpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tgpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [tgpr_pkg::COLOR_W-1:0] ink_color;
  logic [tgpr_pkg::PITCH_W-1:0] row_pitch;

  logic           cmd_push;
  tgpr_pkg::cmd_t cmd_in;
  tgpr_pkg::cmd_t cmd_out;
  logic           cmd_full;
  logic           cmd_empty;
  logic           cmd_pop;

  logic           res_push;
  tgpr_pkg::pix_t res_in;
  tgpr_pkg::pix_t res_out;
  logic           res_full;

  // config registers: always ready, one beat per write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ink_color <= tgpr_pkg::INK_RESET;
      row_pitch <= tgpr_pkg::PITCH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tgpr_pkg::CFG_INK:   ink_color <= cfg_data;
        tgpr_pkg::CFG_PITCH: row_pitch <= cfg_data[tgpr_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: classify each request beat
  tgpr_front u_front (
    .req_type  (req_type),
    .char_code (char_code),
    .glyph_row (glyph_row),
    .row_bits  (row_bits),
    .push      (push),
    .q_full    (cmd_full),
    .q_push    (cmd_push),
    .q_item    (cmd_in)
  );

  assign full = cmd_full;

  tgpr_fifo #(
    .ITEM_T (tgpr_pkg::cmd_t),
    .DEPTH  (tgpr_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_item (cmd_in),
    .rd_en   (cmd_pop),
    .rd_item (cmd_out),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  // back end: font store, cursor and pixel scan
  tgpr_back #(
    .FONT_CHARS (FONT_CHARS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_item  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_in),
    .ink_color (ink_color),
    .row_pitch (row_pitch)
  );

  // result queue decouples the scan from the consumer
  tgpr_fifo #(
    .ITEM_T (tgpr_pkg::pix_t),
    .DEPTH  (tgpr_pkg::RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_item (res_in),
    .rd_en   (pop),
    .rd_item (res_out),
    .full    (res_full),
    .empty   (empty)
  );

  assign pixel_address = res_out.addr;
  assign pixel_color   = res_out.color;
  assign last_pixel    = res_out.last;

`ifndef ASSERT_OFF
  // engine never writes a result beat into a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_push && res_full))
    else $error("result beat pushed while result queue full");

  // engine never dequeues a command that is not there
  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(cmd_pop && cmd_empty))
    else $error("command popped from empty queue");

  // a command is only ever enqueued when the request beat is accepted
  a_cmd_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> (push && !full))
    else $error("command enqueued without an accepted request beat");
`endif

endmodule
